// ----- rtl/fss_pkg.sv -----
package fss_pkg;

  localparam int SLOTS_DEF      = 10;
  localparam int FRAME_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [1:0] CMD_CLAIM   = 2'd0;
  localparam logic [1:0] CMD_DONE    = 2'd1;
  localparam logic [1:0] CMD_PRESENT = 2'd2;

  localparam logic CFG_MOVIE_LEN = 1'b0;
  localparam logic CFG_LOOKAHEAD = 1'b1;

  localparam logic [15:0] MOVIE_LEN_RST = 16'd1;
  localparam logic [3:0]  LOOKAHEAD_RST = 4'd8;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_DECODING = 2'd1,
    ST_READY    = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot_index;
    logic        decode_ok;
    logic [15:0] target_frame;
  } item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  granted_slot;
    logic [15:0] granted_frame;
    logic        presented;
    logic        late;
    logic [31:0] skipped_total;
    logic [31:0] decoded_total;
    logic [31:0] error_total;
    logic [31:0] presented_total;
    logic [31:0] late_total;
  } result_t;

endpackage

// ----- rtl/fss_cell.sv -----
module fss_cell #(
  parameter int FRAME_BITS = fss_pkg::FRAME_BITS_DEF,
  parameter int VAL_W      = 16,
  parameter int IDX_W      = 4,
  parameter int MY_IDX     = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  present_mode,
  input  logic [VAL_W-1:0]      tgt_frame,
  input  logic [VAL_W-1:0]      last_shown,
  input  logic                  any_shown,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  fss_pkg::slot_st_t     wr_status,
  input  logic                  wr_frame_en,
  input  logic [FRAME_BITS-1:0] wr_frame,
  input  logic                  in_found,
  input  logic [IDX_W-1:0]      in_idx,
  input  logic [VAL_W-1:0]      in_frame,
  output logic                  out_found,
  output logic [IDX_W-1:0]      out_idx,
  output logic [VAL_W-1:0]      out_frame
);

  fss_pkg::slot_st_t     status;
  logic [FRAME_BITS-1:0] frame_idx;
  logic [VAL_W-1:0]      own;
  logic                  hit;
  logic                  sel;

  assign own = VAL_W'(frame_idx);
  assign sel = wr_en && (wr_idx == IDX_W'(MY_IDX));

  always_comb begin
    if (present_mode) begin
      hit = (status == fss_pkg::ST_READY) && (own <= tgt_frame) &&
            (!any_shown || (own > last_shown)) && (!in_found || (own > in_frame));
    end else begin
      hit = !in_found && ((status == fss_pkg::ST_FREE) ||
            ((status == fss_pkg::ST_READY) && (own < tgt_frame)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= fss_pkg::ST_FREE;
    end else if (sel) begin
      status <= wr_status;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr_frame_en) begin
      frame_idx <= wr_frame;
    end
  end

  // hand the best candidate so far to the next cell
  always_ff @(posedge clk) begin
    if (hit) begin
      out_found <= 1'b1;
      out_idx   <= IDX_W'(MY_IDX);
      out_frame <= own;
    end else begin
      out_found <= in_found;
      out_idx   <= in_idx;
      out_frame <= in_frame;
    end
  end

endmodule

// ----- rtl/frame_slot_scheduler.sv -----
// Frame slot scheduler: pool of decoded-frame slots for a video player.
// Command channel: item is taken at a rising edge with start high and busy
// low. Commands: claim a slot for decode, decode done, set target frame and present.
// Result channel: one result beat per command, on result for exactly one
// cycle while done is high; the receiver cannot stall, so a beat is never
// held.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 movie
// length, 1 lookahead) at the edge; write only while busy is low.
// Sequencing: claim and set target go from the accepting edge through SCAN,
// where the candidate beat ripples through the row of SLOTS slot cells one
// cell per cycle, and then FINISH before done; decode done and the unused
// code go straight to FINISH. A new command is taken in the cycle that done
// is high.
// Reset (rst, synchronous): all slots free, counters and frame pointers
// zero, movie length 1, lookahead 8, nothing presented yet.
module frame_slot_scheduler #(
  parameter int SLOTS      = fss_pkg::SLOTS_DEF,
  parameter int FRAME_BITS = fss_pkg::FRAME_BITS_DEF,
  parameter int COUNT_BITS = fss_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  fss_pkg::item_t  item,
  output logic            done,
  output fss_pkg::result_t result,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int VAL_W = (FRAME_BITS > 16) ? FRAME_BITS : 16;
  localparam int CMP_W = VAL_W + 1;
  localparam int IDX_W = $clog2(SLOTS);

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t                state;
  logic [IDX_W-1:0]      scan_cnt;
  logic [1:0]            cmd_q;
  logic [3:0]            slot_q;
  logic                  ok_q;
  logic                  claim_ok;
  logic [15:0]           movie_len;
  logic [3:0]            lookahead;
  logic [FRAME_BITS-1:0] next_frame;
  logic [VAL_W-1:0]      current_target;
  logic [VAL_W-1:0]      last_shown;
  logic                  any_shown;
  logic [COUNT_BITS-1:0] skip_count;
  logic [COUNT_BITS-1:0] decode_count;
  logic [COUNT_BITS-1:0] error_count;
  logic [COUNT_BITS-1:0] present_count;
  logic [COUNT_BITS-1:0] late_count;

  logic                  chain_found [SLOTS+1];
  logic [IDX_W-1:0]      chain_idx   [SLOTS+1];
  logic [VAL_W-1:0]      chain_frame [SLOTS+1];

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  fss_pkg::slot_st_t     wr_status;
  logic                  wr_frame_en;

  logic [VAL_W-1:0]      nf_ext;
  logic [VAL_W-1:0]      nf_max;
  logic [VAL_W-1:0]      fc_ext;
  logic [15:0]           clamped;
  logic                  slot_valid;
  logic                  do_grant;
  logic                  new_any;
  logic [VAL_W-1:0]      new_last;

  assign busy = (state != IDLE);

  assign nf_ext     = VAL_W'(next_frame);
  assign nf_max     = (nf_ext < current_target) ? current_target : nf_ext;
  assign fc_ext     = VAL_W'(movie_len);
  assign clamped    = (item.target_frame >= movie_len) ?
                      ((movie_len == 16'd0) ? 16'd0 : movie_len - 16'd1) :
                      item.target_frame;
  assign slot_valid = (int'(slot_q) < SLOTS);
  assign do_grant   = claim_ok && chain_found[SLOTS];
  assign new_any    = any_shown || chain_found[SLOTS];
  assign new_last   = chain_found[SLOTS] ? chain_frame[SLOTS] : last_shown;

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = chain_idx[SLOTS];
    wr_status   = fss_pkg::ST_DECODING;
    wr_frame_en = 1'b0;
    if (state == FINISH) begin
      case (cmd_q)
        fss_pkg::CMD_CLAIM: begin
          wr_en       = do_grant;
          wr_frame_en = 1'b1;
        end
        fss_pkg::CMD_DONE: begin
          wr_en     = slot_valid;
          wr_idx    = IDX_W'(slot_q);
          wr_status = ok_q ? fss_pkg::ST_READY : fss_pkg::ST_FREE;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign chain_found[0] = 1'b0;
  assign chain_idx[0]   = '0;
  assign chain_frame[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    fss_cell #(
      .FRAME_BITS(FRAME_BITS),
      .VAL_W     (VAL_W),
      .IDX_W     (IDX_W),
      .MY_IDX    (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .present_mode(cmd_q == fss_pkg::CMD_PRESENT),
      .tgt_frame   (current_target),
      .last_shown  (last_shown),
      .any_shown   (any_shown),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_status   (wr_status),
      .wr_frame_en (wr_frame_en),
      .wr_frame    (next_frame),
      .in_found    (chain_found[g]),
      .in_idx      (chain_idx[g]),
      .in_frame    (chain_frame[g]),
      .out_found   (chain_found[g+1]),
      .out_idx     (chain_idx[g+1]),
      .out_frame   (chain_frame[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      done          <= 1'b0;
      scan_cnt      <= '0;
      movie_len     <= fss_pkg::MOVIE_LEN_RST;
      lookahead     <= fss_pkg::LOOKAHEAD_RST;
      next_frame    <= '0;
      current_target <= '0;
      last_shown    <= '0;
      any_shown     <= 1'b0;
      skip_count    <= '0;
      decode_count  <= '0;
      error_count   <= '0;
      present_count <= '0;
      late_count    <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          fss_pkg::CFG_MOVIE_LEN: movie_len <= cfg_data;
          fss_pkg::CFG_LOOKAHEAD: lookahead <= cfg_data[3:0];
          default:                movie_len <= movie_len;
        endcase
      end
      case (state)
        IDLE: begin
          if (start) begin
            cmd_q    <= item.cmd;
            slot_q   <= item.slot_index;
            ok_q     <= item.decode_ok;
            scan_cnt <= IDX_W'(SLOTS - 1);
            case (item.cmd)
              fss_pkg::CMD_CLAIM: begin
                // advance to target, then check movie end and window
                if (nf_ext < current_target) begin
                  skip_count <= skip_count + COUNT_BITS'(current_target - nf_ext);
                  next_frame <= FRAME_BITS'(current_target);
                end
                claim_ok <= (nf_max < fc_ext) &&
                            (CMP_W'(nf_max) < (CMP_W'(current_target) + CMP_W'(lookahead)));
                state    <= SCAN;
              end
              fss_pkg::CMD_PRESENT: begin
                current_target <= VAL_W'(clamped);
                state          <= SCAN;
              end
              default: begin
                state <= FINISH;
              end
            endcase
          end
        end
        SCAN: begin
          scan_cnt <= scan_cnt - IDX_W'(1);
          if (scan_cnt == '0) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          result.granted       <= 1'b0;
          result.granted_slot  <= '0;
          result.granted_frame <= '0;
          result.presented     <= 1'b0;
          result.late          <= 1'b0;
          result.skipped_total   <= 32'(skip_count);
          result.decoded_total   <= 32'(decode_count);
          result.error_total     <= 32'(error_count);
          result.presented_total <= 32'(present_count);
          result.late_total      <= 32'(late_count);
          case (cmd_q)
            fss_pkg::CMD_CLAIM: begin
              if (do_grant) begin
                result.granted       <= 1'b1;
                result.granted_slot  <= 4'(chain_idx[SLOTS]);
                result.granted_frame <= 16'(next_frame);
                next_frame           <= next_frame + FRAME_BITS'(1);
              end
            end
            fss_pkg::CMD_DONE: begin
              if (slot_valid) begin
                if (ok_q) begin
                  decode_count          <= decode_count + COUNT_BITS'(1);
                  result.decoded_total  <= 32'(decode_count + COUNT_BITS'(1));
                end else begin
                  error_count           <= error_count + COUNT_BITS'(1);
                  result.error_total    <= 32'(error_count + COUNT_BITS'(1));
                end
              end
            end
            fss_pkg::CMD_PRESENT: begin
              if (chain_found[SLOTS]) begin
                last_shown             <= chain_frame[SLOTS];
                any_shown              <= 1'b1;
                present_count          <= present_count + COUNT_BITS'(1);
                result.presented_total <= 32'(present_count + COUNT_BITS'(1));
                result.presented       <= 1'b1;
                result.granted_slot    <= 4'(chain_idx[SLOTS]);
                result.granted_frame   <= 16'(chain_frame[SLOTS]);
              end
              if (!new_any || (new_last != current_target)) begin
                result.late       <= 1'b1;
                late_count        <= late_count + COUNT_BITS'(1);
                result.late_total <= 32'(late_count + COUNT_BITS'(1));
              end
            end
            default: begin
              result.granted <= 1'b0;
            end
          endcase
          done  <= 1'b1;
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/frame_slot_scheduler_tb.sv -----
`timescale 1ns / 100ps

module frame_slot_scheduler_tb;

  localparam int NSLOT = fss_pkg::SLOTS_DEF;
  localparam int LIMIT = 150000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class slot_pool_model;
    fss_pkg::slot_st_t st[NSLOT];
    logic [15:0]       frame_of[NSLOT];
    bit                ever_granted[NSLOT];
    logic [15:0]       next_fr;
    logic [15:0]       target;
    logic [15:0]       shown_frame;
    bit                shown_any;
    logic [31:0]       skips;
    logic [31:0]       decodes;
    logic [31:0]       errors;
    logic [31:0]       shows;
    logic [31:0]       lates;
    logic [15:0]       movie_len;
    logic [3:0]        lookahead;
    fss_pkg::result_t  due[$];
    int                fails;

    function new();
      foreach (st[i]) begin
        st[i] = fss_pkg::ST_FREE;
        frame_of[i] = '0;
        ever_granted[i] = 1'b0;
      end
      next_fr = '0;
      target = '0;
      shown_frame = '0;
      shown_any = 1'b0;
      skips = '0;
      decodes = '0;
      errors = '0;
      shows = '0;
      lates = '0;
      movie_len = fss_pkg::MOVIE_LEN_RST;
      lookahead = fss_pkg::LOOKAHEAD_RST;
      fails = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == fss_pkg::CFG_MOVIE_LEN) begin
        movie_len = val;
      end else begin
        lookahead = val[3:0];
      end
    endfunction

    function void take_command(fss_pkg::item_t it);
      fss_pkg::result_t r;
      logic [15:0]      tgt;
      logic [15:0]      f;
      int               hit;
      int               best;
      r = '0;
      hit = -1;
      best = -1;
      case (it.cmd)
        fss_pkg::CMD_CLAIM: begin
          tgt = target;
          if (next_fr < tgt) begin
            skips = skips + 32'(tgt - next_fr);
            next_fr = tgt;
          end
          if (next_fr < movie_len &&
              32'(next_fr) < 32'(tgt) + 32'(lookahead)) begin
            for (int i = 0; i < NSLOT; i++) begin
              if (hit < 0 && (st[i] == fss_pkg::ST_FREE ||
                  (st[i] == fss_pkg::ST_READY && frame_of[i] < tgt))) begin
                hit = i;
              end
            end
            if (hit >= 0) begin
              r.granted = 1'b1;
              r.granted_slot = 4'(hit);
              r.granted_frame = next_fr;
              st[hit] = fss_pkg::ST_DECODING;
              frame_of[hit] = next_fr;
              ever_granted[hit] = 1'b1;
              next_fr = next_fr + 16'd1;
            end
          end
        end
        fss_pkg::CMD_DONE: begin
          if (it.slot_index < NSLOT) begin
            st[it.slot_index] = it.decode_ok ? fss_pkg::ST_READY : fss_pkg::ST_FREE;
            if (it.decode_ok) begin
              decodes = decodes + 32'd1;
            end else begin
              errors = errors + 32'd1;
            end
          end
        end
        fss_pkg::CMD_PRESENT: begin
          tgt = it.target_frame;
          if (tgt >= movie_len) begin
            tgt = (movie_len != 0) ? movie_len - 16'd1 : 16'd0;
          end
          target = tgt;
          for (int i = 0; i < NSLOT; i++) begin
            f = frame_of[i];
            if (st[i] == fss_pkg::ST_READY && f <= tgt &&
                (!shown_any || f > shown_frame) &&
                (best < 0 || f > frame_of[best])) begin
              best = i;
            end
          end
          if (best >= 0) begin
            shown_frame = frame_of[best];
            shown_any = 1'b1;
            shows = shows + 32'd1;
            r.presented = 1'b1;
            r.granted_slot = 4'(best);
            r.granted_frame = shown_frame;
          end
          if (!shown_any || shown_frame != tgt) begin
            r.late = 1'b1;
            lates = lates + 32'd1;
          end
        end
        default: begin
        end
      endcase
      r.skipped_total = skips;
      r.decoded_total = decodes;
      r.error_total = errors;
      r.presented_total = shows;
      r.late_total = lates;
      due.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
      end
    endfunction

    function void check_result(fss_pkg::result_t got);
      fss_pkg::result_t want;
      if (due.size() == 0) begin
        fails++;
        if (fails <= 10) begin
          $display("result beat with nothing outstanding");
        end
        return;
      end
      want = due.pop_front();
      cmp("granted", 32'(want.granted), 32'(got.granted));
      cmp("granted_slot", 32'(want.granted_slot), 32'(got.granted_slot));
      cmp("granted_frame", 32'(want.granted_frame), 32'(got.granted_frame));
      cmp("presented", 32'(want.presented), 32'(got.presented));
      cmp("late", 32'(want.late), 32'(got.late));
      cmp("skipped_total", want.skipped_total, got.skipped_total);
      cmp("decoded_total", want.decoded_total, got.decoded_total);
      cmp("error_total", want.error_total, got.error_total);
      cmp("presented_total", want.presented_total, got.presented_total);
      cmp("late_total", want.late_total, got.late_total);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  fss_pkg::item_t   item = '0;
  logic             done;
  fss_pkg::result_t result;
  logic             cfg_we = 1'b0;
  logic             cfg_index = fss_pkg::CFG_MOVIE_LEN;
  logic [15:0]      cfg_data = '0;
  int               cycles = 0;

  slot_pool_model pool = new();

  frame_slot_scheduler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL frame_slot_scheduler");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      pool.check_result(result);
    end
  end

  function automatic fss_pkg::item_t mk(logic [1:0] cmd, logic [3:0] slot, logic ok,
                                        logic [15:0] tgt);
    fss_pkg::item_t it;
    it.cmd = cmd;
    it.slot_index = slot;
    it.decode_ok = ok;
    it.target_frame = tgt;
    return it;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic fss_pkg::item_t random_command();
    fss_pkg::item_t it;
    int             r;
    int             t;
    int             cands[$];
    it = 23'($urandom);
    r = $urandom_range(99);
    if (r < 38) begin
      it.cmd = fss_pkg::CMD_CLAIM;
    end else if (r < 68) begin
      it.cmd = fss_pkg::CMD_DONE;
      for (int i = 0; i < NSLOT; i++) begin
        if (pool.st[i] == fss_pkg::ST_DECODING) begin
          cands.push_back(i);
        end
      end
      if (cands.size() != 0 && $urandom_range(9) < 8) begin
        it.slot_index = 4'(cands[$urandom_range(cands.size() - 1)]);
      end else begin
        it.slot_index = 4'($urandom_range(15));
      end
      it.decode_ok = ($urandom_range(9) < 8);
      // never mark ready a slot whose frame was never set
      if (it.slot_index < NSLOT && !pool.ever_granted[it.slot_index]) begin
        it.decode_ok = 1'b0;
      end
    end else if (r < 95) begin
      it.cmd = fss_pkg::CMD_PRESENT;
      r = $urandom_range(99);
      if (r < 68) begin
        t = int'(pool.target) + int'($urandom_range(3));
      end else if (r < 84) begin
        t = int'(pool.target) - int'($urandom_range(5));
      end else if (r < 92) begin
        t = int'(pool.target) + int'($urandom_range(4, 12));
      end else if (r < 96 && pool.movie_len < 16'd1000) begin
        t = int'(pool.movie_len) - 1 + int'($urandom_range(2));
      end else begin
        t = $urandom_range(16'hFFFF);
      end
      if (t < 0) begin
        t = 0;
      end
      it.target_frame = t[15:0];
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic issue(fss_pkg::item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pool.take_command(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pool.due.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic setup(logic [15:0] fc, logic [3:0] la);
    cfg_we <= 1'b1;
    cfg_index <= fss_pkg::CFG_MOVIE_LEN;
    cfg_data <= fc;
    @(posedge clk);
    pool.set_reg(fss_pkg::CFG_MOVIE_LEN, fc);
    cfg_index <= fss_pkg::CFG_LOOKAHEAD;
    cfg_data <= {12'd0, la};
    @(posedge clk);
    pool.set_reg(fss_pkg::CFG_LOOKAHEAD, {12'd0, la});
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [15:0] fc, logic [3:0] la, int n);
    drain();
    setup(fc, la);
    for (int k = 0; k < n; k++) begin
      issue(random_command(), (k % 40 < 12) ? 0 : pause_len());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(mk(fss_pkg::CMD_CLAIM, 4'd0, 1'b0, 16'd0), 0);
    issue(mk(fss_pkg::CMD_CLAIM, 4'd0, 1'b0, 16'd0), 0);
    issue(mk(fss_pkg::CMD_DONE, 4'd0, 1'b1, 16'd0), 1);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'd0), 0);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'hFFFF), 2);
    issue(mk(CMD_UNUSED, 4'hF, 1'b1, 16'hFFFF), 0);
    issue(mk(fss_pkg::CMD_DONE, 4'd15, 1'b1, 16'd0), 0);
    issue(mk(fss_pkg::CMD_DONE, 4'd10, 1'b0, 16'd0), 3);
    issue(mk(fss_pkg::CMD_DONE, 4'd9, 1'b0, 16'd0), 0);

    drain();
    setup(16'hFFFF, 4'd15);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'hFFFF), 0);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'd0), 0);
    issue(mk(fss_pkg::CMD_CLAIM, 4'd0, 1'b0, 16'd0), 0);

    drain();
    setup(16'd0, 4'd15);
    issue(mk(fss_pkg::CMD_CLAIM, 4'd0, 1'b0, 16'd0), 0);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'd500), 0);

    drain();
    setup(16'd20, 4'd0);
    issue(mk(fss_pkg::CMD_CLAIM, 4'd0, 1'b0, 16'd0), 0);

    drain();
    setup(16'd20, 4'd15);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'd5), 0);
    issue(mk(fss_pkg::CMD_CLAIM, 4'd0, 1'b0, 16'd0), 0);
    issue(mk(fss_pkg::CMD_DONE, 4'd1, 1'b1, 16'd0), 0);
    issue(mk(fss_pkg::CMD_DONE, 4'd0, 1'b1, 16'd0), 0);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'd4), 1);
    issue(mk(fss_pkg::CMD_PRESENT, 4'd0, 1'b0, 16'd9), 0);
    issue(mk(fss_pkg::CMD_CLAIM, 4'd0, 1'b0, 16'd0), 0);
    issue(mk(fss_pkg::CMD_DONE, 4'd1, 1'b0, 16'd0), 0);

    // frame pointer only moves forward, so grow the movie phase by phase
    random_phase(16'd30, 4'd15, 130);
    random_phase(16'd60, 4'd1, 130);
    random_phase(16'd120, 4'd4, 130);
    random_phase(16'($urandom_range(200, 600)), 4'($urandom_range(2, 14)), 130);
    random_phase(16'hFFFF, 4'd15, 130);

    drain();
    repeat (20) @(posedge clk);
    if (pool.fails == 0 && pool.due.size() == 0) begin
      $display("PASS frame_slot_scheduler");
    end else begin
      $display("FAIL frame_slot_scheduler");
    end
    $finish;
  end

endmodule
